// ===== hdl/lrbd_pkg.sv =====
// Shared types and codes for the line rasteriser controller and datapath.
package lrbd_pkg;

	// Input item kinds, carried in the slave-side tuser.
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_STEP  = 1'b1;

	// Line algorithms selected on a start item.
	localparam logic ALG_BRESENHAM = 1'b0;
	localparam logic ALG_DDA       = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // take a start item's endpoints
		logic emit;     // produce one pixel and advance the walk
		logic div_step; // one iteration of the increment division
	} lrbd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic pending;  // points remain on the current line
		logic need_div; // the start item on the input needs a division
		logic div_last; // the division is on its final iteration
	} lrbd_sts_t;

endpackage

// ===== hdl/lrbd_datapath.sv =====
// Datapath of the line rasteriser: set-up, shared walk registers and increment divider.
module lrbd_datapath import lrbd_pkg::*; #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lrbd_cmd_t             cmd,
	output lrbd_sts_t             sts,
	input  logic                  algorithm,
	input  logic [COORD_BITS-1:0] x_start,
	input  logic [COORD_BITS-1:0] y_start,
	input  logic [COORD_BITS-1:0] x_end,
	input  logic [COORD_BITS-1:0] y_end,
	output logic [COORD_BITS:0]   point_x,
	output logic [COORD_BITS:0]   point_y,
	output logic                  last
);

	localparam int C      = COORD_BITS;
	localparam int F      = FRAC_BITS;
	localparam int W      = C + F;
	localparam int DEC_W  = C + 3;
	localparam int CNT_W  = $clog2(F + 1);

	// Set-up arithmetic on the incoming endpoints.
	logic signed [C:0] dx, dy;
	logic [C:0]        dx_mag, dy_mag;
	logic [C-1:0]      adx, ady, major_in, minor_in;
	logic              swap_in;
	logic [DEC_W-1:0]  dec_init;

	// Control state.
	logic         mode_dda_q;
	logic [C-1:0] points_left_q;

	// Line state.
	logic              swapped_q, neg_x_q, neg_y_q;
	logic [C-1:0]      major_q, minor_q;
	logic [DEC_W-1:0]  dec_q;
	logic [W-1:0]      walk_x_q, walk_y_q;
	logic [F+1:0]      step_x_q, step_y_q;
	logic [F+1:0]      unit_pos, unit_neg;

	// Divider.
	logic [C:0]       rem_q, rem_diff, rem_sel, rem_next;
	logic [F:0]       quot_q, quot_next;
	logic [CNT_W-1:0] div_cnt_q;
	logic             rem_ge;
	logic [F+1:0]     quot_ext, quot_signed;
	logic             minor_neg;

	// Walk update.
	logic             dec_ge, adv_x, adv_y;
	logic [DEC_W-1:0] dec_next;
	logic [W-1:0]     walk_x_next, walk_y_next;

	always_comb begin
		dx       = $signed({1'b0, x_end}) - $signed({1'b0, x_start});
		dy       = $signed({1'b0, y_end}) - $signed({1'b0, y_start});
		dx_mag   = dx[C] ? -dx : dx;
		dy_mag   = dy[C] ? -dy : dy;
		adx      = dx_mag[C-1:0];
		ady      = dy_mag[C-1:0];
		swap_in  = ady > adx;
		major_in = swap_in ? ady : adx;
		minor_in = swap_in ? adx : ady;
		dec_init = {2'b00, minor_in, 1'b0} - {3'b000, major_in};
		unit_pos = {2'b01, {F{1'b0}}};
		unit_neg = -unit_pos;
	end

	// One restoring-division iteration of minor * 2^F / major.
	always_comb begin
		rem_ge      = rem_q >= {1'b0, major_q};
		rem_diff    = rem_q - {1'b0, major_q};
		rem_sel     = rem_ge ? rem_diff : rem_q;
		rem_next    = {rem_sel[C-1:0], 1'b0};
		quot_next   = {quot_q[F-1:0], rem_ge};
		quot_ext    = {1'b0, quot_next};
		minor_neg   = swapped_q ? neg_x_q : neg_y_q;
		quot_signed = minor_neg ? -quot_ext : quot_ext;
	end

	// Pixel advance: the major axis always steps, the minor axis on a
	// non-negative decision term in Bresenham mode and always in DDA mode.
	always_comb begin
		dec_ge      = !dec_q[DEC_W-1];
		adv_x       = mode_dda_q || !swapped_q || dec_ge;
		adv_y       = mode_dda_q || swapped_q || dec_ge;
		dec_next    = dec_q + {2'b00, minor_q, 1'b0}
			- (dec_ge ? {2'b00, major_q, 1'b0} : {DEC_W{1'b0}});
		walk_x_next = walk_x_q + {{(W-F-2){step_x_q[F+1]}}, step_x_q};
		walk_y_next = walk_y_q + {{(W-F-2){step_y_q[F+1]}}, step_y_q};
	end

	always_comb begin
		sts.pending  = points_left_q != '0;
		sts.need_div = (algorithm == ALG_DDA) && (major_in != '0);
		sts.div_last = div_cnt_q == CNT_W'(F);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_dda_q    <= 1'b0;
			points_left_q <= '0;
		end else if (cmd.load) begin
			mode_dda_q    <= algorithm == ALG_DDA;
			points_left_q <= major_in;
		end else if (cmd.emit) begin
			points_left_q <= points_left_q - C'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			swapped_q <= swap_in;
			neg_x_q   <= dx[C];
			neg_y_q   <= dy[C];
			major_q   <= major_in;
			minor_q   <= minor_in;
			dec_q     <= dec_init;
			walk_x_q  <= {x_start, {F{1'b0}}};
			walk_y_q  <= {y_start, {F{1'b0}}};
			step_x_q  <= dx[C] ? unit_neg : unit_pos;
			step_y_q  <= dy[C] ? unit_neg : unit_pos;
			rem_q     <= {1'b0, minor_in};
			quot_q    <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q     <= rem_next;
			quot_q    <= quot_next;
			div_cnt_q <= div_cnt_q + CNT_W'(1);
			if (sts.div_last) begin
				if (swapped_q) begin
					step_x_q <= quot_signed;
				end else begin
					step_y_q <= quot_signed;
				end
			end
		end else if (cmd.emit) begin
			dec_q <= dec_next;
			if (adv_x) begin
				walk_x_q <= walk_x_next;
			end
			if (adv_y) begin
				walk_y_q <= walk_y_next;
			end
		end
	end

	// Output register: DDA emits floor(accumulator) + 1, Bresenham the position.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			point_x <= {1'b0, walk_x_q[W-1:F]} + {{C{1'b0}}, mode_dda_q};
			point_y <= {1'b0, walk_y_q[W-1:F]} + {{C{1'b0}}, mode_dda_q};
			last    <= points_left_q == C'(1);
		end
	end

endmodule

// ===== hdl/lrbd_ctrl.sv =====
// Controller of the line rasteriser: handshakes, division sequencing and output valid.
module lrbd_ctrl import lrbd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_kind,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output lrbd_cmd_t cmd,
	input  lrbd_sts_t sts
);

	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_DIVIDE = 2'b10
	} lrbd_state_t;

	lrbd_state_t state_q, state_d;
	logic        out_valid_q;
	logic        accept;

	always_comb begin
		in_ready     = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
		accept       = in_valid && in_ready;
		cmd.load     = accept && (in_kind == KIND_START);
		cmd.emit     = accept && (in_kind == KIND_STEP) && sts.pending;
		cmd.div_step = state_q == ST_DIVIDE;
		out_valid    = out_valid_q;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.load && sts.need_div) begin
					state_d = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (sts.div_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hdl/line_rasterizer_bresenham_dda.sv =====
// A step transfer shows its pixel on the master side in the cycle after acceptance. Step
// transfers stream at one pixel per cycle through the output register while m_axis_tready is
// high. A Bresenham start needs no division; a DDA start of non-zero length holds tready
// low while the one-bit-per-cycle divider forms the minor increment.
// Reset (arst_n low, asynchronous) leaves no line pending and the master side empty.
// Top level of the line rasteriser: stream ports, field packing, controller and datapath.
module line_rasterizer_bresenham_dda import lrbd_pkg::*; #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 20
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// Fields from bit 0 up: x_start, y_start, x_end, y_end, then zero fill.
	input  logic [((4*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,
	// Fields from bit 0 up: kind, algorithm.
	input  logic [1:0]                            s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// Fields from bit 0 up: point_x, point_y, then zero fill.
	output logic [((2*(COORD_BITS+1)+7)/8)*8-1:0] m_axis_tdata,
	output logic                                  m_axis_tlast
);

	localparam int C = COORD_BITS;

	lrbd_cmd_t cmd;
	lrbd_sts_t sts;

	logic [C:0] point_x, point_y;

	// The controller owns both handshakes. A start transfer loads the line; in DDA mode, for a
	// non-zero length, it then runs the divider before the next transfer is taken. A step transfer
	// with points pending moves one pixel into the output register, which may be refilled in the
	// same cycle that its previous pixel is taken on the master side.
	lrbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_kind   (s_axis_tuser[0]),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// The datapath keeps both axes as Q.FRAC_BITS accumulators. Bresenham mode steps
	// them by whole units, the minor axis gated on the decision term; DDA mode adds the
	// major unit and the divided minor increment every pixel.
	lrbd_datapath #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.algorithm (s_axis_tuser[1]),
		.x_start   (s_axis_tdata[C-1:0]),
		.y_start   (s_axis_tdata[2*C-1:C]),
		.x_end     (s_axis_tdata[3*C-1:2*C]),
		.y_end     (s_axis_tdata[4*C-1:3*C]),
		.point_x   (point_x),
		.point_y   (point_y),
		.last      (m_axis_tlast)
	);

	// Pack the pixel into tdata with zero fill above it.
	always_comb begin
		m_axis_tdata              = '0;
		m_axis_tdata[C:0]         = point_x;
		m_axis_tdata[2*C+1:C+1]   = point_y;
	end

endmodule
